>>> design/sbg_pkg.sv
// sbg_pkg: shared types and constants of the scan bin gap filler
// request/result payloads, register decode, controller states, command/status groups
// no dependencies
package sbg_pkg;

	localparam logic [15:0] EMPTY_CODE = 16'hFFFF;
	localparam logic [15:0] MAX_STORED = 16'hFFFE;
	// x / 5 == (x * DIV5_MUL) >> DIV5_SHIFT, exact for x below 2**18
	localparam logic [15:0] DIV5_MUL   = 16'd52429;
	localparam int          DIV5_SHIFT = 18;
	localparam logic [15:0] DIST_ROUND = 16'd20;
	localparam logic [15:0] ANGLE_ROUND = 16'd32;
	localparam int          RUN_W      = 4;
	localparam logic [RUN_W-1:0] RUN_SAT = 4'd8;

	localparam int PADDR_W = 4;

	typedef enum logic [1:0] {
		REG_MIN_RANGE = 2'd0,
		REG_MAX_RANGE = 2'd1,
		REG_MAX_GAP   = 2'd2
	} sbg_reg_t;

	typedef struct packed {
		logic        req_type;
		logic [15:0] angle_q6;
		logic [15:0] distance_q2;
		logic [8:0]  read_index;
	} sbg_item_t;

	typedef struct packed {
		logic [15:0] bin_value;
		logic        bin_empty;
		logic        point_stored;
		logic [8:0]  bins_filled;
	} sbg_result_t;

	typedef struct packed {
		logic [13:0] min_range_mm;
		logic [13:0] max_range_mm;
		logic [2:0]  max_gap;
	} sbg_cfg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_POINT,
		ST_SCAN,
		ST_FILL,
		ST_RESP
	} sbg_state_t;

	typedef struct packed {
		logic latch;
		logic rd_issue;
		logic pt_wr;
		logic scan_start;
		logic scan_rd;
		logic fill_wr;
		logic clr_wr;
		logic load_out;
	} sbg_cmd_t;

	typedef struct packed {
		logic new_is_read;
		logic clear_done;
		logic fill_hit;
		logic fill_last;
		logic scan_done;
		logic out_free;
	} sbg_status_t;

endpackage

>>> design/scan_bin_gap_filler_core.sv
// scan_bin_gap_filler_core: top level of the scan bin gap filler
// depends on sbg_pkg, sbg_cfg_regs, sbg_ctrl, sbg_datapath
//
// Holds a scan of BIN_COUNT range bins in one single-port-write, single-port-read
// memory. After reset a clearing pass writes the empty code to every bin, one per
// cycle, before the first request is taken; register writes are accepted throughout.
// A read request issues its memory read, then loads its result into the output register.
// A point request writes its bin, then walks the memory one bin per cycle; for each
// run it fills it stops to take the average and then writes each bin of the run
// before the walk goes on. One request is worked on at a time; a finished result
// waits in an output register while the next request is taken, and a new result
// that finds that register still full waits until it is taken.
module scan_bin_gap_filler_core
	import sbg_pkg::*;
#(
	parameter int BIN_COUNT     = 360,
	parameter int FRACTION_BITS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  sbg_item_t          item,
	output logic               result_valid,
	input  logic               result_ready,
	output sbg_result_t        result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	sbg_cfg_t    cfg;
	sbg_cmd_t    cmd;
	sbg_status_t st;

	sbg_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sbg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.st         (st),
		.cmd        (cmd)
	);

	sbg_datapath #(
		.BIN_COUNT     (BIN_COUNT),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.item         (item),
		.cmd          (cmd),
		.st           (st),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

>>> design/sbg_cfg_regs.sv
// sbg_cfg_regs: APB register file for range limits and longest fillable gap
// depends on sbg_pkg
module sbg_cfg_regs
	import sbg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output sbg_cfg_t           cfg
);

	sbg_cfg_t cfg_q;
	logic     wr_en;
	sbg_reg_t reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = sbg_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_range_mm <= 14'd150;
			cfg_q.max_range_mm <= 14'd6000;
			cfg_q.max_gap      <= 3'd3;
		end else if (wr_en) begin
			case (reg_sel)
				REG_MIN_RANGE: cfg_q.min_range_mm <= pwdata[13:0];
				REG_MAX_RANGE: cfg_q.max_range_mm <= pwdata[13:0];
				REG_MAX_GAP:   cfg_q.max_gap      <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_MIN_RANGE: prdata = {18'd0, cfg_q.min_range_mm};
			REG_MAX_RANGE: prdata = {18'd0, cfg_q.max_range_mm};
			REG_MAX_GAP:   prdata = {29'd0, cfg_q.max_gap};
			default:       prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

>>> design/sbg_ctrl.sv
// sbg_ctrl: sequencer for clear, point write, bin walk with gap fill, read and response
// depends on sbg_pkg
module sbg_ctrl
	import sbg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  sbg_status_t st,
	output sbg_cmd_t    cmd
);

	sbg_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (st.clear_done) state_d = ST_IDLE;
			ST_IDLE: begin
				if (item_valid) state_d = st.new_is_read ? ST_READ : ST_POINT;
			end
			ST_READ:  state_d = ST_RESP;
			ST_POINT: state_d = ST_SCAN;
			ST_SCAN: begin
				if (st.fill_hit) state_d = ST_FILL;
				else if (st.scan_done) state_d = ST_RESP;
			end
			ST_FILL:  if (st.fill_last) state_d = ST_SCAN;
			ST_RESP:  if (st.out_free) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.clr_wr = 1'b1;
			ST_IDLE: begin
				item_ready = 1'b1;
				cmd.latch  = item_valid;
			end
			ST_READ: cmd.rd_issue = 1'b1;
			ST_POINT: begin
				cmd.pt_wr      = 1'b1;
				cmd.scan_start = 1'b1;
			end
			// hold off the next read when a run to fill is found
			ST_SCAN:  cmd.scan_rd  = ~st.fill_hit;
			ST_FILL:  cmd.fill_wr  = 1'b1;
			ST_RESP:  cmd.load_out = st.out_free;
			default: ;
		endcase
	end

endmodule

>>> design/sbg_datapath.sv
// sbg_datapath: bin memory, point scaling, walk and fill counters, result register
// depends on sbg_pkg; driven by sbg_ctrl commands
module sbg_datapath
	import sbg_pkg::*;
#(
	parameter int BIN_COUNT     = 360,
	parameter int FRACTION_BITS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  sbg_cfg_t    cfg,
	input  sbg_item_t   item,
	input  sbg_cmd_t    cmd,
	output sbg_status_t st,
	output logic        result_valid,
	input  logic        result_ready,
	output sbg_result_t result
);

	localparam int IDX_W = $clog2(BIN_COUNT);
	localparam int CNT_W = $clog2(BIN_COUNT + 1);
	localparam int SW    = 16 + FRACTION_BITS;
	localparam logic [CNT_W-1:0] BIN_END  = CNT_W'(BIN_COUNT);
	localparam logic [CNT_W-1:0] BIN_LAST = CNT_W'(BIN_COUNT - 1);

	logic [15:0] mem [BIN_COUNT];

	sbg_item_t   item_q;
	logic [15:0] rd_data_q;
	logic        rd_oob_q;
	logic        stored_q;
	logic [8:0]  filled_q;
	logic [CNT_W-1:0] clr_ptr_q;
	logic [CNT_W-1:0] raddr_q;
	logic [CNT_W-1:0] pidx_s1;
	logic             rvalid_s1;
	logic [RUN_W-1:0] run_q;
	logic [CNT_W-1:0] start_q;
	logic [15:0]      left_q;
	logic [15:0]      avg_q;
	logic [CNT_W-1:0] fptr_q;
	logic [CNT_W-1:0] fend_q;
	sbg_result_t      result_q;
	logic             result_valid_q;

	// point scaling
	logic [16:0]      angle_sum;
	logic [10:0]      bin_idx;
	logic             bin_ok;
	logic             in_range;
	logic [16:0]      dist_sum;
	logic [29:0]      div_prod;
	logic [11:0]      cm;
	logic [SW-1:0]    scaled;
	logic [15:0]      pt_value;

	// walk
	logic             bin_is_empty;
	logic             scan_issue;
	logic [16:0]      pair_sum;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [15:0]      wr_data;
	logic             read_ok;
	logic [15:0]      read_value;

	assign angle_sum = {1'b0, item_q.angle_q6} + {1'b0, ANGLE_ROUND};
	assign bin_idx   = angle_sum[16:6];
	assign bin_ok    = bin_idx < 11'(BIN_COUNT);
	assign in_range  = (item_q.distance_q2 >= {cfg.min_range_mm, 2'b00})
		&& (item_q.distance_q2 <= {cfg.max_range_mm, 2'b00});

	// (d + 20) / 40 as ((d + 20) >> 3) / 5
	assign dist_sum = {1'b0, item_q.distance_q2} + {1'b0, DIST_ROUND};
	assign div_prod = dist_sum[16:3] * DIV5_MUL;
	assign cm       = div_prod[29:DIV5_SHIFT];
	assign scaled   = SW'(cm) << FRACTION_BITS;
	assign pt_value = !in_range ? EMPTY_CODE
		: (scaled > SW'(MAX_STORED)) ? MAX_STORED : scaled[15:0];

	assign bin_is_empty = rd_data_q == EMPTY_CODE;
	assign pair_sum     = {1'b0, left_q} + {1'b0, rd_data_q};
	assign scan_issue   = cmd.scan_rd && (raddr_q < BIN_END);
	assign read_ok      = {1'b0, item_q.read_index} < 10'(BIN_COUNT);

	assign st.new_is_read = item.req_type;
	assign st.clear_done  = clr_ptr_q == BIN_LAST;
	assign st.fill_hit    = rvalid_s1 && !bin_is_empty && (run_q != '0)
		&& (run_q <= {1'b0, cfg.max_gap}) && (left_q != EMPTY_CODE);
	assign st.fill_last   = (fptr_q + 1'b1) == fend_q;
	assign st.scan_done   = (raddr_q == BIN_END) && !rvalid_s1;
	assign st.out_free    = !result_valid_q || result_ready;

	// memory port selection
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = raddr_q[IDX_W-1:0];
		if (scan_issue) begin
			rd_en = 1'b1;
		end else if (cmd.rd_issue && read_ok) begin
			rd_en   = 1'b1;
			rd_addr = IDX_W'(item_q.read_index);
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = fptr_q[IDX_W-1:0];
		wr_data = avg_q;
		if (cmd.clr_wr) begin
			wr_en   = 1'b1;
			wr_addr = clr_ptr_q[IDX_W-1:0];
			wr_data = EMPTY_CODE;
		end else if (cmd.pt_wr && bin_ok) begin
			wr_en   = 1'b1;
			wr_addr = bin_idx[IDX_W-1:0];
			wr_data = pt_value;
		end else if (cmd.fill_wr) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) item_q <= item;
		if (cmd.rd_issue) rd_oob_q <= !read_ok;
		if (cmd.pt_wr) stored_q <= bin_ok;
		if (st.fill_hit) begin
			avg_q  <= pair_sum[16:1];
			fptr_q <= start_q;
			fend_q <= pidx_s1;
		end else if (cmd.fill_wr) begin
			fptr_q <= fptr_q + 1'b1;
		end
		if (scan_issue) pidx_s1 <= raddr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_ptr_q <= '0;
			raddr_q   <= '0;
			rvalid_s1 <= 1'b0;
			run_q     <= '0;
			start_q   <= '0;
			left_q    <= '0;
			filled_q  <= '0;
		end else begin
			if (cmd.clr_wr) clr_ptr_q <= clr_ptr_q + 1'b1;
			rvalid_s1 <= scan_issue;
			if (cmd.scan_start) begin
				raddr_q  <= '0;
				run_q    <= '0;
				left_q   <= '0;
				filled_q <= '0;
			end else begin
				if (scan_issue) raddr_q <= raddr_q + 1'b1;
				if (cmd.fill_wr) filled_q <= filled_q + 1'b1;
				if (rvalid_s1) begin
					if (bin_is_empty) begin
						if (run_q == '0) start_q <= pidx_s1;
						if (run_q != RUN_SAT) run_q <= run_q + 1'b1;
					end else begin
						left_q <= rd_data_q;
						run_q  <= '0;
					end
				end
			end
		end
	end

	assign read_value = rd_oob_q ? EMPTY_CODE : rd_data_q;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (item_q.req_type) begin
				result_q.bin_value    <= read_value;
				result_q.bin_empty    <= read_value == EMPTY_CODE;
				result_q.point_stored <= 1'b0;
				result_q.bins_filled  <= '0;
			end else begin
				result_q.bin_value    <= '0;
				result_q.bin_empty    <= 1'b0;
				result_q.point_stored <= stored_q;
				result_q.bins_filled  <= filled_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

>>> dv/tb_scan_bin_gap_filler_core.sv
// tb_scan_bin_gap_filler_core: self-checking testbench of the scan bin gap filler
// keeps its own copy of the bin scan and ranges, checks every result in order
// depends on sbg_pkg and scan_bin_gap_filler_core
module tb_scan_bin_gap_filler_core;
	import sbg_pkg::*;

	localparam int NUM_BINS     = 360;
	localparam int FRAC         = 4;
	localparam int RANDOM_ITEMS = 680;
	localparam int PHASE_ITEMS  = 70;
	localparam int IDLE_PCT     = 34;
	localparam int IDLE_PAD     = 4;
	localparam int DRAIN_CYCLES = 800;
	localparam int STALL_LIMIT  = 6000;

	localparam logic REQ_POINT = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               item_valid   = 1'b0;
	logic               item_ready;
	sbg_item_t          item         = '0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	sbg_result_t        result;
	logic               psel         = 1'b0;
	logic               penable      = 1'b0;
	logic               pwrite       = 1'b0;
	logic [PADDR_W-1:0] paddr        = '0;
	logic [31:0]        pwdata       = '0;
	logic [31:0]        prdata;
	logic               pready;

	// predicted scan and ranges
	logic [15:0] scan_bins [NUM_BINS];
	logic [13:0] cfg_min_mm = 14'd150;
	logic [13:0] cfg_max_mm = 14'd6000;
	logic [2:0]  cfg_gap    = 3'd3;

	sbg_result_t reply_q [$];
	int          error_count = 0;
	int          reply_count = 0;
	logic        idle_on     = 1'b1;
	int          focus_bin   = 0;

	scan_bin_gap_filler_core #(
		.BIN_COUNT     (NUM_BINS),
		.FRACTION_BITS (FRAC)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #2 clk = ~clk;

	initial begin
		for (int i = 0; i < NUM_BINS; i++)
			scan_bins[i] = EMPTY_CODE;
	end

	function automatic logic [15:0] quantize_cm(logic [15:0] dq2);
		logic [31:0] cm_v;
		cm_v = ((32'(dq2) + 32'(DIST_ROUND)) / 32'd40) << FRAC;
		return (cm_v > 32'(MAX_STORED)) ? MAX_STORED : cm_v[15:0];
	endfunction

	// runs up to cfg_gap long take the truncated mean of both neighbors
	function automatic logic [8:0] fill_short_gaps();
		int          run_len;
		int          run_start;
		int          filled;
		logic [16:0] left_v;
		logic [16:0] pair_sum;
		logic [15:0] avg;
		run_len = 0;
		run_start = 0;
		filled = 0;
		for (int i = 0; i < NUM_BINS; i++) begin
			if (scan_bins[i] == EMPTY_CODE) begin
				if (run_len == 0)
					run_start = i;
				run_len++;
			end else begin
				if (run_len > 0 && run_len <= int'(cfg_gap)) begin
					left_v = (run_start > 0) ? {1'b0, scan_bins[run_start-1]} : 17'd0;
					if (left_v != {1'b0, EMPTY_CODE}) begin
						pair_sum = left_v + {1'b0, scan_bins[i]};
						avg = pair_sum[16:1];
						for (int j = run_start; j < i; j++) begin
							scan_bins[j] = avg;
							filled++;
						end
					end
				end
				run_len = 0;
			end
		end
		return filled[8:0];
	endfunction

	function automatic sbg_result_t apply_request(sbg_item_t it);
		sbg_result_t r;
		logic [31:0] bin_idx;
		logic [31:0] lo_q2;
		logic [31:0] hi_q2;
		r = '0;
		if (it.req_type == REQ_READ) begin
			r.bin_value = (it.read_index < NUM_BINS) ? scan_bins[it.read_index] : EMPTY_CODE;
			r.bin_empty = (r.bin_value == EMPTY_CODE);
		end else begin
			bin_idx = (32'(it.angle_q6) + 32'(ANGLE_ROUND)) >> 6;
			if (bin_idx < NUM_BINS) begin
				lo_q2 = 32'(cfg_min_mm) * 4;
				hi_q2 = 32'(cfg_max_mm) * 4;
				if (32'(it.distance_q2) >= lo_q2 && 32'(it.distance_q2) <= hi_q2)
					scan_bins[bin_idx] = quantize_cm(it.distance_q2);
				else
					scan_bins[bin_idx] = EMPTY_CODE;
				r.point_stored = 1'b1;
			end
			r.bins_filled = fill_short_gaps();
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		error_count++;
		$display("mismatch at result %0d: %s got %0d want %0d", reply_count, what, got, want);
	endtask

	task automatic check_reply(sbg_result_t got);
		sbg_result_t want;
		if (reply_q.size() == 0) begin
			report_mismatch("unexpected result, bin_value", got.bin_value, 0);
		end else begin
			want = reply_q.pop_front();
			if (got.bin_value !== want.bin_value)
				report_mismatch("bin_value", got.bin_value, want.bin_value);
			if (got.bin_empty !== want.bin_empty)
				report_mismatch("bin_empty", got.bin_empty, want.bin_empty);
			if (got.point_stored !== want.point_stored)
				report_mismatch("point_stored", got.point_stored, want.point_stored);
			if (got.bins_filled !== want.bins_filled)
				report_mismatch("bins_filled", got.bins_filled, want.bins_filled);
		end
		reply_count++;
	endtask

	always @(posedge clk) begin
		if (result_valid === 1'b1 && result_ready)
			check_reply(result);
		result_ready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// watchdog on cycles without any handshake
	initial begin : watchdog
		int stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_valid && item_ready === 1'b1) || (result_valid === 1'b1 && result_ready)
					|| (psel && penable && pwrite && pready === 1'b1))
				stall = 0;
			else
				stall++;
		end
		$display("watchdog expired after %0d idle cycles", STALL_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	task automatic send_request(logic req, logic [15:0] angle, logic [15:0] dist_q2,
			logic [8:0] ridx);
		sbg_item_t it;
		it.req_type = req;
		it.angle_q6 = angle;
		it.distance_q2 = dist_q2;
		it.read_index = ridx;
		if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_ready !== 1'b1);
		reply_q.push_back(apply_request(it));
	endtask

	task automatic wait_idle();
		item_valid <= 1'b0;
		while (reply_q.size() != 0)
			@(posedge clk);
		repeat (IDLE_PAD) @(posedge clk);
	endtask

	task automatic write_reg(sbg_reg_t idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		// leave the bus idle before the next access
		@(posedge clk);
		case (idx)
			REG_MIN_RANGE: cfg_min_mm = val[13:0];
			REG_MAX_RANGE: cfg_max_mm = val[13:0];
			REG_MAX_GAP:   cfg_gap = val[2:0];
			default: ;
		endcase
	endtask

	// junk fills the unused upper bits of each write
	task automatic set_config(logic [13:0] mn, logic [13:0] mx, logic [2:0] gp, logic junk);
		logic [31:0] hi_bits;
		wait_idle();
		hi_bits = junk ? $urandom() : 32'd0;
		write_reg(REG_MIN_RANGE, {hi_bits[31:14], mn});
		write_reg(REG_MAX_RANGE, {hi_bits[31:14], mx});
		write_reg(REG_MAX_GAP, {hi_bits[31:3], gp});
	endtask

	function automatic logic [15:0] angle_for_bin(int b);
		if (b == 0)
			return 16'($urandom_range(0, 31));
		return 16'(b * 64 - 32 + $urandom_range(0, 63));
	endfunction

	function automatic logic [15:0] in_range_dist();
		int lo_q2;
		int hi_q2;
		lo_q2 = int'(cfg_min_mm) * 4;
		hi_q2 = int'(cfg_max_mm) * 4;
		if (lo_q2 > hi_q2)
			return 16'($urandom_range(0, 65535));
		return 16'($urandom_range(lo_q2, hi_q2));
	endfunction

	function automatic logic [15:0] out_range_dist();
		int lo_q2;
		int hi_q2;
		lo_q2 = int'(cfg_min_mm) * 4;
		hi_q2 = int'(cfg_max_mm) * 4;
		if (lo_q2 > 0 && $urandom_range(0, 1) == 0)
			return 16'($urandom_range(0, lo_q2 - 1));
		return 16'($urandom_range(hi_q2 + 1, 65535));
	endfunction

	task automatic test_reset_reads();
		send_request(REQ_READ, 16'd0, 16'd0, 9'd0);
		send_request(REQ_READ, 16'hFFFF, 16'hFFFF, 9'd359);
		send_request(REQ_READ, 16'd0, 16'd0, 9'd360);
		send_request(REQ_READ, 16'd0, 16'd0, 9'd511);
	endtask

	task automatic test_point_edges();
		// run at bin zero takes 0 as its left neighbor
		send_request(REQ_POINT, 16'd128, 16'd600, 9'd0);
		send_request(REQ_POINT, 16'd31, 16'd24000, 9'h1FF);
		send_request(REQ_POINT, 16'd32, 16'd599, 9'd0);
		// last bin, then angles past the last bin
		send_request(REQ_POINT, 16'd23007, 16'd24001, 9'd0);
		send_request(REQ_POINT, 16'd23008, 16'd1000, 9'd0);
		send_request(REQ_POINT, 16'hFFFF, 16'hFFFF, 9'd0);
		send_request(REQ_POINT, 16'd415, 16'd4000, 9'd0);
		send_request(REQ_POINT, 16'd704, 16'd5000, 9'd0);
		send_request(REQ_READ, 16'd0, 16'd0, 9'd1);
		send_request(REQ_READ, 16'd0, 16'd0, 9'd4);
		send_request(REQ_READ, 16'd0, 16'd0, 9'd8);
	endtask

	task automatic test_range_limits();
		set_config(14'd16383, 14'd0, 3'd3, 1'b0);
		send_request(REQ_POINT, 16'd0, 16'd0, 9'd0);
		set_config(14'd0, 14'd16383, 3'd3, 1'b0);
		send_request(REQ_POINT, 16'd576, 16'd0, 9'd0);
		send_request(REQ_POINT, 16'd640, 16'd65535, 9'd0);
		send_request(REQ_POINT, 16'd640, 16'd65532, 9'd0);
		send_request(REQ_READ, 16'd0, 16'd0, 9'd10);
	endtask

	task automatic test_gap_settings();
		set_config(14'd150, 14'd6000, 3'd7, 1'b0);
		send_request(REQ_POINT, 16'd1024, 16'd8000, 9'd0);
		set_config(14'd150, 14'd6000, 3'd0, 1'b0);
		send_request(REQ_POINT, 16'd1024, 16'd100, 9'd0);
		send_request(REQ_READ, 16'd0, 16'd0, 9'd16);
	endtask

	task automatic test_random_traffic();
		int          phase_n;
		int          sent;
		int          k;
		int          r;
		int          b;
		int          burst_len;
		logic [13:0] mn;
		logic [13:0] mx;
		logic [2:0]  gp;
		phase_n = 0;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case (phase_n)
				0: begin mn = 14'd150;   mx = 14'd6000;  gp = 3'd3; end
				1: begin mn = 14'd0;     mx = 14'd16383; gp = 3'd7; end
				2: begin mn = 14'd150;   mx = 14'd6000;  gp = 3'd0; end
				3: begin mn = 14'd1000;  mx = 14'd2000;  gp = 3'd2; end
				4: begin mn = 14'd16383; mx = 14'd0;     gp = 3'd5; end
				5: begin mn = 14'd0;     mx = 14'd0;     gp = 3'd1; end
				6: begin mn = 14'd16383; mx = 14'd16383; gp = 3'd4; end
				7: begin mn = 14'd500;   mx = 14'd12000; gp = 3'd7; end
				default: begin
					mn = ($urandom_range(0, 1) == 0) ? 14'($urandom_range(0, 2000))
						: 14'($urandom_range(0, 16383));
					mx = ($urandom_range(0, 4) == 0) ? 14'($urandom_range(0, 16383))
						: 14'($urandom_range(int'(mn), 16383));
					gp = 3'($urandom_range(0, 7));
				end
			endcase
			set_config(mn, mx, gp, phase_n >= 8);
			// one phase runs with both sides always ready
			idle_on <= (phase_n != 2);
			focus_bin = $urandom_range(0, NUM_BINS - 1);
			k = 0;
			while (k < PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 45) begin
					b = ($urandom_range(0, 1) == 0) ? (focus_bin + $urandom_range(0, 19)) % NUM_BINS
						: $urandom_range(0, NUM_BINS - 1);
					send_request(REQ_POINT, angle_for_bin(b), in_range_dist(),
						9'($urandom_range(0, 511)));
					k++;
				end else if (r < 60) begin
					// consecutive empty bins to open up runs
					b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NUM_BINS - 1)
						: (focus_bin + $urandom_range(0, 19)) % NUM_BINS;
					burst_len = $urandom_range(1, 9);
					for (int j = 0; j < burst_len; j++) begin
						send_request(REQ_POINT, angle_for_bin((b + j) % NUM_BINS), out_range_dist(),
							9'($urandom_range(0, 511)));
						k++;
					end
				end else if (r < 80) begin
					send_request(REQ_READ, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
						($urandom_range(0, 4) == 0) ? 9'($urandom_range(0, 511))
						: 9'($urandom_range(0, NUM_BINS - 1)));
					k++;
				end else if (r < 90) begin
					send_request(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
						16'($urandom_range(0, 65535)), 9'($urandom_range(0, 511)));
					k++;
				end else begin
					send_request(REQ_POINT, angle_for_bin($urandom_range(0, NUM_BINS - 1)),
						16'($urandom_range(0, 65535)), 9'($urandom_range(0, 511)));
					k++;
				end
			end
			sent += k;
			phase_n++;
		end
		idle_on <= 1'b1;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_reads();
		test_point_edges();
		test_range_limits();
		test_gap_settings();
		test_random_traffic();
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (reply_q.size() != 0)
			report_mismatch("results never delivered", reply_q.size(), 0);
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> filelist.f
design/sbg_pkg.sv
design/sbg_cfg_regs.sv
design/sbg_ctrl.sv
design/sbg_datapath.sv
design/scan_bin_gap_filler_core.sv
dv/tb_scan_bin_gap_filler_core.sv
